// ===== src/tdp_pkg.sv =====
// shared constants and types for the trial division prime test
package tdp_pkg;

  localparam int NUMBER_WIDTH = 32;
  localparam int CANDIDATE_WIDTH = 32;
  localparam int CNT_WIDTH = $clog2(NUMBER_WIDTH + 1);

  localparam logic [NUMBER_WIDTH-1:0] NUM_ONE = NUMBER_WIDTH'(1);
  localparam logic [NUMBER_WIDTH-1:0] NUM_TWO = NUMBER_WIDTH'(2);
  localparam logic [NUMBER_WIDTH-1:0] NUM_THREE = NUMBER_WIDTH'(3);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_OUT
  } tdp_state_t;

  typedef struct packed {
    logic valid;
    logic [NUMBER_WIDTH-1:0] quotient;
    logic [NUMBER_WIDTH-1:0] remainder;
  } div_result_t;

endpackage

// ===== src/tdp_divider.sv =====
// radix-2 restoring divider, one quotient bit per cycle
module tdp_divider (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic [tdp_pkg::NUMBER_WIDTH-1:0] dividend,
  input  logic [tdp_pkg::NUMBER_WIDTH-1:0] divisor,
  output tdp_pkg::div_result_t result
);
  import tdp_pkg::*;

  logic [CNT_WIDTH-1:0] cnt_r;
  logic [NUMBER_WIDTH-1:0] rem_r;
  logic [NUMBER_WIDTH-1:0] quo_r;
  logic [NUMBER_WIDTH-1:0] dsr_r;
  logic done_r;

  logic [NUMBER_WIDTH:0] trial;
  logic [NUMBER_WIDTH:0] diff;
  logic fits;

  always_comb begin
    trial = {rem_r, quo_r[NUMBER_WIDTH-1]};
    diff = trial - {1'b0, dsr_r};
    fits = trial >= {1'b0, dsr_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CNT_WIDTH'(NUMBER_WIDTH);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - CNT_WIDTH'(1);
        if (cnt_r == CNT_WIDTH'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (cnt_r != '0) begin
      // dividend bits shift out the top as quotient bits shift in
      quo_r <= {quo_r[NUMBER_WIDTH-2:0], fits};
      rem_r <= fits ? diff[NUMBER_WIDTH-1:0] : trial[NUMBER_WIDTH-1:0];
    end
  end

  assign result.valid = done_r;
  assign result.quotient = quo_r;
  assign result.remainder = rem_r;

endmodule

// ===== src/trial_division_prime_test.sv =====
// Primality test by trial division with odd divisors and a shared serial divider.
// Candidates below 3 and even candidates: the result is registered in the cycle after
// the candidate is taken. Odd candidates: one serial division per trial divisor (one bit
// per cycle in the divider), up to about 2^15 divisors for 32-bit inputs.
// Throughput: one transaction at a time; the next is taken after the result is taken.
// Reset: synchronous active-low rst_n returns to idle with no result pending.
module trial_division_prime_test (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  logic [tdp_pkg::CANDIDATE_WIDTH-1:0] in_candidate,
  output logic out_valid,
  input  logic out_stall,
  output logic out_is_prime
);
  import tdp_pkg::*;

  tdp_state_t state_r, state_nxt;
  logic [NUMBER_WIDTH-1:0] n_r, n_nxt;
  logic [NUMBER_WIDTH-1:0] d_r, d_nxt;
  logic out_valid_r, out_valid_nxt;
  logic prime_r, prime_nxt;

  logic [NUMBER_WIDTH-1:0] cand;
  logic div_start;
  div_result_t div_res;

  tdp_divider u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (n_nxt),
    .divisor  (d_nxt),
    .result   (div_res)
  );

  assign cand = NUMBER_WIDTH'(in_candidate);

  always_comb begin
    state_nxt = state_r;
    n_nxt = n_r;
    d_nxt = d_r;
    out_valid_nxt = out_valid_r;
    prime_nxt = prime_r;
    div_start = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (cand <= NUM_ONE) begin
            prime_nxt = 1'b0;
            out_valid_nxt = 1'b1;
            state_nxt = ST_OUT;
          end else if (cand == NUM_TWO) begin
            prime_nxt = 1'b1;
            out_valid_nxt = 1'b1;
            state_nxt = ST_OUT;
          end else if (!cand[0]) begin
            prime_nxt = 1'b0;
            out_valid_nxt = 1'b1;
            state_nxt = ST_OUT;
          end else begin
            n_nxt = cand;
            d_nxt = NUM_THREE;
            div_start = 1'b1;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_res.valid) begin
          // d > n / d means d * d > n, so no divisor is left to try
          if (d_r > div_res.quotient) begin
            prime_nxt = 1'b1;
            out_valid_nxt = 1'b1;
            state_nxt = ST_OUT;
          end else if (div_res.remainder == '0) begin
            prime_nxt = 1'b0;
            out_valid_nxt = 1'b1;
            state_nxt = ST_OUT;
          end else begin
            d_nxt = d_r + NUM_TWO;
            div_start = 1'b1;
          end
        end
      end
      ST_OUT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r <= n_nxt;
    d_r <= d_nxt;
    prime_r <= prime_nxt;
  end

  assign in_stall = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_is_prime = prime_r;

endmodule
